// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, idle while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, also during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/frv_pkg.sv =====
package frv_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CODE_W = 32;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic              op_push;
    logic              op_pop;
    logic              op_rem;
    logic [CODE_W-1:0] code;
  } frv_ctrl_t;

endpackage

// ===== hdl/frv_cell.sv =====
module frv_cell
  import frv_pkg::*;
(
  input  logic              clk,
  input  frv_ctrl_t         ctrl,
  input  logic              valid_i,
  input  logic              tail_i,
  input  logic              hit_i,
  output logic              hit_o,
  input  logic [CODE_W-1:0] nbr_data_i,
  output logic [CODE_W-1:0] data_o
);

  logic [CODE_W-1:0] data_r;
  logic [CODE_W-1:0] data_nxt;
  logic              match;

  assign match  = ctrl.op_rem && valid_i && (data_r == ctrl.code);
  assign hit_o  = hit_i || match;
  assign data_o = data_r;

  // push writes the free cell at the tail; pop or a removal at/before here shifts down
  always_comb begin
    data_nxt = data_r;
    priority if (ctrl.op_push && tail_i) begin
      data_nxt = ctrl.code;
    end else if (ctrl.op_pop || hit_o) begin
      data_nxt = nbr_data_i;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ===== hdl/fifo_with_remove_by_value.sv =====
// Bounded FIFO of 32-bit codes with push, pop-head and remove-by-value.
// Input channel in_*: one command beat per handshake, tdata carries the
// command and the code. Output channel out_*: exactly one result beat per
// command, with the popped or removed code, a status, the occupancy after
// the command and an empty flag.
// Storage is a row of DEPTH cells, head in cell 0. Every cell compares its
// code at once and a hit ripples toward the tail, so a removal closes the
// gap in the same cycle as the search.
// The result is registered when the command is accepted and appears in the next cycle.
// Throughput: one command per cycle while out_tready stays high.
// When the receiver stalls, the result is held in the output register and
// in_tready drops until it is taken; no command is lost.
// Reset (rst_n low, synchronous) empties the queue and clears out_tvalid;
// cell contents are not cleared and are never read before being written.
module fifo_with_remove_by_value
  import frv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] command, [33:2] code_in, [39:34] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] code_out, [33:32] status,
                                  // [38:34] occupancy, [39] is_empty
);

`include "assert_macros.svh"

  logic              in_fire;
  logic [1:0]        cmd;
  logic [CODE_W-1:0] code_in;
  frv_ctrl_t         ctrl;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic [39:0]       out_data_r;

  logic              full;
  logic              empty;
  logic              found;
  logic [CODE_W-1:0] res_code;
  logic [1:0]        res_status;

  logic [CODE_W-1:0] cell_data [DEPTH];
  logic [DEPTH:0]    hit;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign cmd        = in_tdata[1:0];
  assign code_in    = in_tdata[33:2];
  assign full       = (count_r == CNT_W'(DEPTH));
  assign empty      = (count_r == '0);

  assign ctrl.op_push = in_fire && (cmd == CMD_PUSH) && !full;
  assign ctrl.op_pop  = in_fire && (cmd == CMD_POP) && !empty;
  assign ctrl.op_rem  = in_fire && (cmd == CMD_REMOVE);
  assign ctrl.code    = code_in;

  assign hit[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [CODE_W-1:0] nbr;
    if (g == DEPTH - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_data[g+1];
    end
    frv_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid_i    (CNT_W'(g) < count_r),
      .tail_i     (CNT_W'(g) == count_r),
      .hit_i      (hit[g]),
      .hit_o      (hit[g+1]),
      .nbr_data_i (nbr),
      .data_o     (cell_data[g])
    );
  end

  assign found = hit[DEPTH];

  always_comb begin
    count_nxt  = count_r;
    res_code   = '0;
    res_status = ST_OK;
    unique case (cmd)
      CMD_PUSH: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_code  = cell_data[0];
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else if (!found) begin
          res_status = ST_NOT_FOUND;
        end else begin
          res_code  = code_in;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {(count_nxt == '0), 5'(count_nxt), res_status, res_code};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ASSERT_CLK(a_count_bound, count_r <= CNT_W'(DEPTH), "occupancy above depth")

  `ASSERT_CLK(a_push_grows, ctrl.op_push |=> count_r == $past(count_r) + CNT_W'(1), "push lost")

  `ASSERT_CLK(a_stall_holds, out_valid_r && !out_tready |-> !in_tready, "accept during stall")

  `ASSERT_CLK(a_rem_shrinks, found |=> count_r == $past(count_r) - CNT_W'(1), "remove lost")

endmodule

// ===== bench/fifo_with_remove_by_value_tb.sv =====
module fifo_with_remove_by_value_tb;
  import frv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SEGMENTS = 17;
  localparam int SEG_BEATS = 50;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [1:0]        status;
    logic [CNT_W-1:0]  occupancy;
    logic              is_empty;
  } result_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [CODE_W-1:0] code;
    int                reps;
    bit                typed;
    result_t           want;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  logic [CODE_W-1:0] held_codes[$];
  result_t           pending_results[$];
  int                errors = 0;
  int                out_beats = 0;
  int                cycles = 0;
  bit                no_idle = 1'b0;

  step_t plan[0:12] = '{
    '{CMD_POP,    32'h0000_0000, 1,  1'b1, '{32'h0, ST_EMPTY, 5'd0, 1'b1}},
    '{CMD_REMOVE, 32'h0000_0000, 1,  1'b1, '{32'h0, ST_EMPTY, 5'd0, 1'b1}},
    '{CMD_NOP,    32'hFFFF_FFFF, 1,  1'b1, '{32'h0, ST_OK, 5'd0, 1'b1}},
    '{CMD_PUSH,   32'h0000_0000, 1,  1'b1, '{32'h0, ST_OK, 5'd1, 1'b0}},
    '{CMD_PUSH,   32'hFFFF_FFFF, 1,  1'b1, '{32'h0, ST_OK, 5'd2, 1'b0}},
    '{CMD_PUSH,   32'h5A5A_5A5A, 1,  1'b0, '0},
    '{CMD_REMOVE, 32'h5A5A_5A5A, 1,  1'b1, '{32'h5A5A_5A5A, ST_OK, 5'd2, 1'b0}},
    '{CMD_REMOVE, 32'h1234_5678, 1,  1'b1, '{32'h0, ST_NOT_FOUND, 5'd2, 1'b0}},
    '{CMD_REMOVE, 32'h0000_0000, 1,  1'b1, '{32'h0, ST_OK, 5'd1, 1'b0}},
    '{CMD_PUSH,   32'hA5A5_A5A0, 15, 1'b0, '0},
    '{CMD_PUSH,   32'h1357_2468, 1,  1'b1, '{32'h0, ST_FULL, 5'd16, 1'b0}},
    '{CMD_REMOVE, 32'hA5A5_A5A7, 1,  1'b1, '{32'hA5A5_A5A7, ST_OK, 5'd15, 1'b0}},
    '{CMD_POP,    32'h0000_0000, 1,  1'b1, '{32'hFFFF_FFFF, ST_OK, 5'd14, 1'b0}}
  };

  fifo_with_remove_by_value i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic result_t apply_command(input logic [1:0] cmd,
                                            input logic [CODE_W-1:0] code);
    result_t r;
    int      hit;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    case (cmd)
      CMD_PUSH: begin
        if (held_codes.size() >= DEPTH) r.status = ST_FULL;
        else held_codes.push_back(code);
      end
      CMD_POP: begin
        if (held_codes.size() == 0) r.status = ST_EMPTY;
        else r.code = held_codes.pop_front();
      end
      CMD_REMOVE: begin
        if (held_codes.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          foreach (held_codes[i])
            if (hit < 0 && held_codes[i] == code) hit = i;
          if (hit < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.code = code;
            held_codes.delete(hit);
          end
        end
      end
      default: ;
    endcase
    r.occupancy = CNT_W'(held_codes.size());
    r.is_empty = (held_codes.size() == 0);
    return r;
  endfunction

  task automatic flag_error(input string what, input logic [CODE_W-1:0] got,
                            input logic [CODE_W-1:0] want);
    if (errors < MAX_PRINTS)
      $display("ERROR result beat %0d: %s got %h want %h", out_beats, what, got, want);
    errors++;
  endtask

  task automatic issue_command(input logic [1:0] cmd, input logic [CODE_W-1:0] code,
                               input bit typed, input result_t want);
    result_t predicted;
    while (!no_idle && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, code, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = apply_command(cmd, code);
    pending_results.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[31:0], out_tdata[33:32], out_tdata[38:34], out_tdata[39]};
      if (pending_results.size() == 0) begin
        flag_error("unexpected beat", got.code, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.code != want.code) flag_error("code_out", got.code, want.code);
        if (got.status != want.status)
          flag_error("status", CODE_W'(got.status), CODE_W'(want.status));
        if (got.occupancy != want.occupancy)
          flag_error("occupancy", CODE_W'(got.occupancy), CODE_W'(want.occupancy));
        if (got.is_empty != want.is_empty)
          flag_error("is_empty", CODE_W'(got.is_empty), CODE_W'(want.is_empty));
      end
      out_beats++;
    end
    out_tready <= no_idle || ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("fifo_with_remove_by_value: mismatch");
      $finish;
    end
  end

  initial begin
    logic [1:0]        cmd;
    logic [CODE_W-1:0] code;
    int                r;
    int                mode;
    int                push_lim;
    int                pop_lim;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i])
      for (int k = 0; k < plan[i].reps; k++)
        issue_command(plan[i].cmd, plan[i].code + k, plan[i].typed, plan[i].want);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      mode = seg % 3;
      no_idle = (seg >= 6 && seg < 9);
      if (seg % 4 == 3) begin
        in_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      // fill-heavy, drain-heavy and balanced mixes
      push_lim = (mode == 0) ? 65 : (mode == 1) ? 25 : 45;
      pop_lim = (mode == 0) ? 75 : (mode == 1) ? 60 : 65;
      for (int n = 0; n < SEG_BEATS; n++) begin
        r = $urandom_range(99);
        if (r >= 96) cmd = CMD_NOP;
        else if (r < push_lim) cmd = CMD_PUSH;
        else if (r < pop_lim) cmd = CMD_POP;
        else cmd = CMD_REMOVE;
        // draw codes from the queue or a small pool so removes hit and duplicates occur
        r = $urandom_range(99);
        if (r < 40 && held_codes.size() != 0)
          code = held_codes[$urandom_range(held_codes.size() - 1)];
        else if (r < 70)
          code = $urandom_range(7);
        else
          code = $urandom;
        issue_command(cmd, code, 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("fifo_with_remove_by_value: match");
    else
      $display("fifo_with_remove_by_value: mismatch");
    $finish;
  end

endmodule
